[sv/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the byte-level I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // command codes carried in the op field of a request
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_RESTART = 3'd2,
        OP_STOP    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RS_REL = 4'd1,
        PH_RS_SCL = 4'd2,
        PH_ST_SDA = 4'd3,
        PH_ST_SCL = 4'd4,
        PH_SETUP  = 4'd5,
        PH_RISE   = 4'd6,
        PH_FALL   = 4'd7,
        PH_SP_SDA = 4'd8,
        PH_SP_SCL = 4'd9,
        PH_SP_END = 4'd10
    } phase_t;

    // configuration register indexes
    localparam logic CFG_HIGH_DELAY = 1'b0;
    localparam logic CFG_LOW_DELAY  = 1'b1;

    // register widths and reset values
    localparam int unsigned CFG_WIDTH       = 16;
    localparam logic [15:0] HIGH_DELAY_INIT = 16'd40;
    localparam logic [15:0] LOW_DELAY_INIT  = 16'd64;
    localparam logic [3:0]  DATA_BITS       = 4'd8;

endpackage

[sv/i2c_master_byte_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Tick-driven I2C master: steps open-drain SCL/SDA levels through start,
// restart, stop, write-byte and read-byte sequences.
// ----------------------------------------------------------------------------
// Every input request is one bus tick and yields exactly one result: the pin
// levels after that tick, an idle flag and, at the end of a read, the
// received byte. A request is taken while the result register is free or
// being read; the state is updated in the same cycle it is accepted and the
// result sits in an output register, so one request per clock is sustained
// while the result side keeps up. A command (op) is acted on only in a request
// whose tick finds the sequencer idle; otherwise it is dropped. Bit timing
// comes from the high and low delay registers, counted in requests; a delay
// of zero adds no ticks. Bytes go out MSB first, the slave ACK is not checked
// and SCL stretching is not observed.
module i2c_master_byte_sequencer #(
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], byte_in[10:3], ack_in[11], sda_in[12]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl_level[0], sda_level[1], ready_res[2],
                                   // rx_valid[3], rx_byte[11:4]
);

    // configuration registers
    logic [i2cms_pkg::CFG_WIDTH-1:0] high_delay_reg;
    logic [i2cms_pkg::CFG_WIDTH-1:0] low_delay_reg;

    // sequencer state
    i2cms_pkg::phase_t        phase_reg, phase_next;
    i2cms_pkg::op_t           cmd_reg, cmd_next;
    logic [3:0]               bit_count_reg, bit_count_next;
    logic [7:0]               shift_reg, shift_next;
    logic [DELAY_WIDTH-1:0]   wait_reg, wait_next;
    logic                     send_ack_reg, send_ack_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic                     done;

    // result register
    logic                     m_valid_reg;
    logic [15:0]              m_data_reg;

    // request fields
    logic [2:0]               op_in;
    logic [7:0]               byte_in;
    logic                     ack_in;
    logic                     sda_in;
    logic                     s_accept;

    // command seen by the action logic
    logic                     take;
    logic                     act;
    i2cms_pkg::phase_t        eff_phase;
    i2cms_pkg::op_t           eff_cmd;
    logic [7:0]               eff_shift;
    logic [3:0]               eff_bit;
    logic                     eff_ack;

    logic [DELAY_WIDTH-1:0]   high_delay;
    logic [DELAY_WIDTH-1:0]   low_delay;

    assign op_in    = s_tdata[2:0];
    assign byte_in  = s_tdata[10:3];
    assign ack_in   = s_tdata[11];
    assign sda_in   = s_tdata[12];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign high_delay = DELAY_WIDTH'(high_delay_reg);
    assign low_delay  = DELAY_WIDTH'(low_delay_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_delay_reg <= i2cms_pkg::HIGH_DELAY_INIT;
            low_delay_reg  <= i2cms_pkg::LOW_DELAY_INIT;
        end else if (cfg_we) begin
            if (cfg_addr == i2cms_pkg::CFG_HIGH_DELAY) begin
                high_delay_reg <= cfg_wdata;
            end else begin
                low_delay_reg <= cfg_wdata;
            end
        end
    end

    // command decode: when idle, a command loads the state its first action sees
    always_comb begin
        take      = 1'b0;
        eff_phase = phase_reg;
        eff_cmd   = cmd_reg;
        eff_shift = shift_reg;
        eff_bit   = bit_count_reg;
        eff_ack   = send_ack_reg;
        if (phase_reg == i2cms_pkg::PH_IDLE) begin
            take    = 1'b1;
            eff_cmd = i2cms_pkg::op_t'(op_in);
            unique case (op_in)
                i2cms_pkg::OP_START: begin
                    eff_shift = byte_in;
                    eff_phase = i2cms_pkg::PH_ST_SDA;
                end
                i2cms_pkg::OP_RESTART: begin
                    eff_shift = byte_in;
                    eff_phase = i2cms_pkg::PH_RS_REL;
                end
                i2cms_pkg::OP_STOP: begin
                    eff_phase = i2cms_pkg::PH_SP_SDA;
                end
                i2cms_pkg::OP_WRITE: begin
                    eff_shift = byte_in;
                    eff_bit   = '0;
                    eff_phase = i2cms_pkg::PH_SETUP;
                end
                i2cms_pkg::OP_READ: begin
                    eff_shift = '0;
                    eff_ack   = ack_in;
                    eff_bit   = '0;
                    eff_phase = i2cms_pkg::PH_SETUP;
                end
                default: begin
                    take    = 1'b0;
                    eff_cmd = cmd_reg;
                end
            endcase
        end
    end

    // an action runs on a taken command or when a pending wait has run out
    assign act = s_accept && (take || (phase_reg != i2cms_pkg::PH_IDLE && wait_reg == '0));

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (act) begin
            unique case (eff_phase)
                i2cms_pkg::PH_RS_REL: phase_next = i2cms_pkg::PH_RS_SCL;
                i2cms_pkg::PH_RS_SCL: phase_next = i2cms_pkg::PH_ST_SDA;
                i2cms_pkg::PH_ST_SDA: phase_next = i2cms_pkg::PH_ST_SCL;
                i2cms_pkg::PH_ST_SCL: phase_next = i2cms_pkg::PH_SETUP;
                i2cms_pkg::PH_SETUP:  phase_next = i2cms_pkg::PH_RISE;
                i2cms_pkg::PH_RISE:   phase_next = i2cms_pkg::PH_FALL;
                i2cms_pkg::PH_FALL: begin
                    if (eff_bit >= i2cms_pkg::DATA_BITS) begin
                        phase_next = i2cms_pkg::PH_IDLE;
                    end else begin
                        phase_next = i2cms_pkg::PH_SETUP;
                    end
                end
                i2cms_pkg::PH_SP_SDA: phase_next = i2cms_pkg::PH_SP_SCL;
                i2cms_pkg::PH_SP_SCL: phase_next = i2cms_pkg::PH_SP_END;
                default:              phase_next = i2cms_pkg::PH_IDLE;
            endcase
        end
    end

    // pin levels, counters and shift register
    always_comb begin
        cmd_next       = eff_cmd;
        shift_next     = eff_shift;
        bit_count_next = eff_bit;
        send_ack_next  = eff_ack;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        wait_next      = wait_reg;
        done           = 1'b0;
        if (!s_accept) begin
            cmd_next       = cmd_reg;
            shift_next     = shift_reg;
            bit_count_next = bit_count_reg;
            send_ack_next  = send_ack_reg;
        end else if (act) begin
            unique case (eff_phase)
                i2cms_pkg::PH_RS_REL: begin
                    sda_next  = 1'b1;
                    wait_next = high_delay;
                end
                i2cms_pkg::PH_RS_SCL: begin
                    scl_next  = 1'b1;
                    wait_next = '0;
                end
                i2cms_pkg::PH_ST_SDA: begin
                    sda_next  = 1'b0;
                    wait_next = high_delay;
                end
                i2cms_pkg::PH_ST_SCL: begin
                    scl_next       = 1'b0;
                    wait_next      = '0;
                    bit_count_next = '0;
                end
                i2cms_pkg::PH_SETUP: begin
                    if (eff_cmd == i2cms_pkg::OP_READ) begin
                        sda_next = (eff_bit < i2cms_pkg::DATA_BITS) ? 1'b1 : !eff_ack;
                    end else begin
                        sda_next = (eff_bit < i2cms_pkg::DATA_BITS) ? eff_shift[7] : 1'b1;
                    end
                    wait_next = low_delay;
                end
                i2cms_pkg::PH_RISE: begin
                    scl_next  = 1'b1;
                    wait_next = high_delay;
                end
                i2cms_pkg::PH_FALL: begin
                    scl_next  = 1'b0;
                    wait_next = '0;
                    if (eff_bit >= i2cms_pkg::DATA_BITS) begin
                        done = (eff_cmd == i2cms_pkg::OP_READ);
                    end else begin
                        // read samples SDA while SCL is still high at this input
                        if (eff_cmd == i2cms_pkg::OP_READ) begin
                            shift_next = {eff_shift[6:0], sda_in};
                        end else begin
                            shift_next = {eff_shift[6:0], 1'b0};
                        end
                        bit_count_next = eff_bit + 4'd1;
                    end
                end
                i2cms_pkg::PH_SP_SDA: begin
                    sda_next  = 1'b0;
                    wait_next = high_delay;
                end
                i2cms_pkg::PH_SP_SCL: begin
                    scl_next  = 1'b1;
                    wait_next = high_delay;
                end
                i2cms_pkg::PH_SP_END: begin
                    sda_next  = 1'b1;
                    wait_next = '0;
                end
                default: begin
                    wait_next = '0;
                end
            endcase
        end else if (phase_reg != i2cms_pkg::PH_IDLE) begin
            // counting down a wait
            wait_next = wait_reg - 1'b1;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= i2cms_pkg::PH_IDLE;
            cmd_reg       <= i2cms_pkg::OP_NONE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            send_ack_reg  <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end else begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            wait_reg      <= wait_next;
            send_ack_reg  <= send_ack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {4'd0,
                           done ? shift_next : 8'd0,
                           done,
                           phase_next == i2cms_pkg::PH_IDLE,
                           sda_next,
                           scl_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a completed read always leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[3] |-> m_data_reg[2])
        else $error("read completion reported while busy");

    // bit counter never passes the ACK slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= i2cms_pkg::DATA_BITS)
        else $error("bit counter out of range");

    // no wait is left pending when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == i2cms_pkg::PH_IDLE |-> wait_reg == '0)
        else $error("wait pending in idle");

    // state holds when no request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(phase_reg) && $stable(wait_reg) && $stable(scl_reg))
        else $error("state moved without a request");

    // a stop ends with both lines released
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == i2cms_pkg::PH_SP_END && wait_reg == '0
        |=> scl_reg && sda_reg && phase_reg == i2cms_pkg::PH_IDLE)
        else $error("stop did not release the bus");

endmodule

[dv/i2c_master_byte_sequencer_chk.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_chk
// Watches the request, result and configuration ports of the I2C byte
// sequencer, predicts the pin levels, idle flag and read byte for every
// accepted request, and compares each returned result with the oldest
// prediction. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], byte_in[10:3], ack_in[11], sda_in[12]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // scl_level[0], sda_level[1], ready_res[2],
                                   // rx_valid[3], rx_byte[11:4]
    input  logic        end_of_test,
    output int unsigned fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_REPORTS = 10;

    // one result as it sits in m_tdata[11:0]
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       idle;
        logic       sda;
        logic       scl;
    } pin_state_t;

    // predicted sequencer state and delay registers
    i2cms_pkg::phase_t seq_phase;
    logic [2:0]  seq_cmd;
    logic [3:0]  seq_bits;
    logic [7:0]  seq_shift;
    logic [15:0] seq_wait;
    logic        seq_ack;
    logic        scl_q;
    logic        sda_q;
    logic [15:0] high_ticks;
    logic [15:0] low_ticks;

    pin_state_t  pin_state_q[$];
    int unsigned result_idx;
    bit          closed;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // one pin action of the current phase, flags a finished read byte
    task automatic bus_action(input logic sda_smp, output logic rd_done);
        rd_done = 1'b0;
        case (seq_phase)
            i2cms_pkg::PH_RS_REL: begin
                sda_q = 1'b1; seq_wait = high_ticks; seq_phase = i2cms_pkg::PH_RS_SCL;
            end
            i2cms_pkg::PH_RS_SCL: begin
                scl_q = 1'b1; seq_wait = '0; seq_phase = i2cms_pkg::PH_ST_SDA;
            end
            i2cms_pkg::PH_ST_SDA: begin
                sda_q = 1'b0; seq_wait = high_ticks; seq_phase = i2cms_pkg::PH_ST_SCL;
            end
            i2cms_pkg::PH_ST_SCL: begin
                scl_q     = 1'b0;
                seq_wait  = '0;
                seq_bits  = '0;
                seq_phase = i2cms_pkg::PH_SETUP;
            end
            i2cms_pkg::PH_SETUP: begin
                if (seq_cmd == i2cms_pkg::OP_READ) begin
                    sda_q = (seq_bits < i2cms_pkg::DATA_BITS) ? 1'b1 : ~seq_ack;
                end else begin
                    sda_q = (seq_bits < i2cms_pkg::DATA_BITS) ? seq_shift[7] : 1'b1;
                end
                seq_wait  = low_ticks;
                seq_phase = i2cms_pkg::PH_RISE;
            end
            i2cms_pkg::PH_RISE: begin
                scl_q = 1'b1; seq_wait = high_ticks; seq_phase = i2cms_pkg::PH_FALL;
            end
            i2cms_pkg::PH_FALL: begin
                scl_q    = 1'b0;
                seq_wait = '0;
                if (seq_bits >= i2cms_pkg::DATA_BITS) begin
                    // ack slot done, byte finished
                    seq_phase = i2cms_pkg::PH_IDLE;
                    rd_done   = (seq_cmd == i2cms_pkg::OP_READ);
                end else begin
                    // read shifts in the level seen while scl was high
                    seq_shift = {seq_shift[6:0],
                                 (seq_cmd == i2cms_pkg::OP_READ) ? sda_smp : 1'b0};
                    seq_bits  = seq_bits + 4'd1;
                    seq_phase = i2cms_pkg::PH_SETUP;
                end
            end
            i2cms_pkg::PH_SP_SDA: begin
                sda_q = 1'b0; seq_wait = high_ticks; seq_phase = i2cms_pkg::PH_SP_SCL;
            end
            i2cms_pkg::PH_SP_SCL: begin
                scl_q = 1'b1; seq_wait = high_ticks; seq_phase = i2cms_pkg::PH_SP_END;
            end
            i2cms_pkg::PH_SP_END: begin
                sda_q = 1'b1; seq_wait = '0; seq_phase = i2cms_pkg::PH_IDLE;
            end
            default: seq_phase = i2cms_pkg::PH_IDLE;
        endcase
    endtask

    // one bus tick: command decode when idle, else wait or act
    task automatic predict_tick(input logic [15:0] req, output pin_state_t res);
        logic [2:0] op_code;
        logic [7:0] data_in;
        logic       ack_bit;
        logic       sda_bit;
        logic       take;
        logic       rd_done;
        op_code = req[2:0];
        data_in = req[10:3];
        ack_bit = req[11];
        sda_bit = req[12];
        rd_done = 1'b0;
        if (seq_phase == i2cms_pkg::PH_IDLE) begin
            take = 1'b1;
            case (op_code)
                i2cms_pkg::OP_START: begin
                    seq_shift = data_in; seq_phase = i2cms_pkg::PH_ST_SDA;
                end
                i2cms_pkg::OP_RESTART: begin
                    seq_shift = data_in; seq_phase = i2cms_pkg::PH_RS_REL;
                end
                i2cms_pkg::OP_STOP: begin
                    seq_phase = i2cms_pkg::PH_SP_SDA;
                end
                i2cms_pkg::OP_WRITE: begin
                    seq_shift = data_in; seq_bits = '0; seq_phase = i2cms_pkg::PH_SETUP;
                end
                i2cms_pkg::OP_READ: begin
                    seq_shift = '0;
                    seq_ack   = ack_bit;
                    seq_bits  = '0;
                    seq_phase = i2cms_pkg::PH_SETUP;
                end
                default: take = 1'b0;
            endcase
            if (take) begin
                seq_cmd  = op_code;
                seq_wait = '0;
                bus_action(sda_bit, rd_done);
            end
        end else if (seq_wait != '0) begin
            seq_wait = seq_wait - 16'd1;
        end else begin
            bus_action(sda_bit, rd_done);
        end
        res.scl      = scl_q;
        res.sda      = sda_q;
        res.idle     = (seq_phase == i2cms_pkg::PH_IDLE);
        res.rx_valid = rd_done;
        res.rx_byte  = rd_done ? seq_shift : 8'h00;
    endtask

    // predict on requests, compare on results
    always @(posedge aclk) begin
        pin_state_t want;
        pin_state_t got;
        if (!aresetn) begin
            seq_phase  = i2cms_pkg::PH_IDLE;
            seq_cmd    = '0;
            seq_bits   = '0;
            seq_shift  = '0;
            seq_wait   = '0;
            seq_ack    = 1'b0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            high_ticks = i2cms_pkg::HIGH_DELAY_INIT;
            low_ticks  = i2cms_pkg::LOW_DELAY_INIT;
            result_idx = 0;
            closed     = 1'b0;
            fail_count = 0;
            pin_state_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == i2cms_pkg::CFG_HIGH_DELAY) high_ticks = cfg_wdata;
                else                                       low_ticks  = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata, want);
                pin_state_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = pin_state_t'(m_tdata[11:0]);
                if (pin_state_q.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with no request pending: %h",
                                           result_idx, m_tdata));
                end else begin
                    want = pin_state_q.pop_front();
                    if (got.scl !== want.scl || got.sda !== want.sda ||
                        got.idle !== want.idle || got.rx_valid !== want.rx_valid ||
                        got.rx_byte !== want.rx_byte || m_tdata[15:12] !== 4'h0) begin
                        note_failure($sformatf({"result %0d: expected scl=%b sda=%b idle=%b ",
                            "rx_valid=%b rx_byte=%02h pad=0, got scl=%b sda=%b idle=%b ",
                            "rx_valid=%b rx_byte=%02h pad=%h"}, result_idx,
                            want.scl, want.sda, want.idle, want.rx_valid, want.rx_byte,
                            got.scl, got.sda, got.idle, got.rx_valid, got.rx_byte,
                            m_tdata[15:12]));
                    end
                end
                result_idx++;
            end
            // anything still waiting at the end never came back
            if (end_of_test && !closed) begin
                closed = 1'b1;
                if (pin_state_q.size() != 0) begin
                    note_failure($sformatf("%0d results never returned", pin_state_q.size()));
                end
            end
        end
    end

endmodule

[dv/i2c_master_byte_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_tb
// Drives bus-tick requests into the I2C byte sequencer: a stop at the reset
// delays, directed start, restart, stop, write and read commands at zero
// delays, then random transactions over several short delay settings.
// Sender bursts, receiver stalls and long receiver hold-offs are mixed in;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 7;
    localparam int          SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int          NOISE_WINDOW  = 20;
    localparam int          STOP_NOISE    = 2;
    localparam int          LONG_HOLD     = 400;
    localparam int          RAND_PHASES   = 4;
    localparam int          ITEM_GOAL     = 900;

    // undefined op codes, ignored by the sequencer
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        end_of_test = 1'b0;
    int unsigned fail_count;

    // stimulus bookkeeping
    int res_count     = 0;
    int last_idle_idx = -1;
    int sent_count    = 0;
    int cmd_idx       = 0;
    int burst_left    = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    i2c_master_byte_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2c_master_byte_sequencer_chk chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .end_of_test (end_of_test),
        .fail_count  (fail_count)
    );

    // track the latest result that reported the sequencer idle
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (m_tdata[2]) last_idle_idx <= res_count;
            res_count <= res_count + 1;
        end
    end

    // result side stall pattern, with a few long hold-offs
    initial begin : result_sink
        int mode;
        int span;
        int holds;
        int unsigned rx_cycles;
        int unsigned hold_at;
        mode      = 0;
        span      = 0;
        holds     = 0;
        rx_cycles = 0;
        hold_at   = 300;
        forever begin
            @(negedge aclk);
            rx_cycles++;
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 300);
            end
            span--;
            if (holds < 3 && rx_cycles >= hold_at) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                holds++;
                hold_at = hold_at + 1000;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (rx_cycles % 4 != 0);
                    default: m_tready <= (rx_cycles % 4 == 0);
                endcase
            end
        end
    end

    // one request, sent in bursts with random gaps; returns at a falling edge
    task automatic send_req(input logic [2:0] op, input logic [7:0] data,
                            input logic ack, input logic sda);
        int gap;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sda, ack, data, op};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        burst_left--;
        @(negedge aclk);
    endtask

    function automatic logic [2:0] filler_op();
        case ($urandom_range(0, 3))
            0: return OP_RSVD6;
            1: return OP_RSVD7;
            default: return i2cms_pkg::OP_NONE;
        endcase
    endfunction

    // plain ticks until a result shows the last command finished
    task automatic wait_idle();
        while (last_idle_idx < cmd_idx) begin
            send_req(filler_op(), 8'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
    endtask

    // sender pause until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (res_count != sent_count) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic settle();
        wait_idle();
        drain();
    endtask

    task automatic set_delays(input logic [15:0] high_t, input logic [15:0] low_t);
        cfg_we    <= 1'b1;
        cfg_addr  <= i2cms_pkg::CFG_HIGH_DELAY;
        cfg_wdata <= high_t;
        @(negedge aclk);
        cfg_addr  <= i2cms_pkg::CFG_LOW_DELAY;
        cfg_wdata <= low_t;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 9))
            0, 1, 2:    return 16'd0;
            3, 4, 5, 6: return 16'($urandom_range(1, 2));
            7, 8:       return 16'($urandom_range(3, 5));
            default:    return 16'($urandom_range(6, 8));
        endcase
    endfunction

    // command once idle, then a few ticks of commands that must be ignored
    task automatic issue(input logic [2:0] op, input logic [7:0] data, input logic ack);
        int noise;
        wait_idle();
        cmd_idx = sent_count;
        send_req(op, data, ack, 1'($urandom_range(0, 1)));
        if (op == i2cms_pkg::OP_STOP) noise = $urandom_range(0, STOP_NOISE);
        else noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NOISE_WINDOW) : 0;
        repeat (noise) begin
            send_req(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
    endtask

    // mostly start / data / optional restart / stop, sometimes loose commands
    task automatic run_transaction();
        int n;
        if ($urandom_range(0, 7) != 0) begin
            issue(i2cms_pkg::OP_START, 8'($urandom), 1'b0);
            n = $urandom_range(1, 2);
            repeat (n) issue($urandom_range(0, 1) ? i2cms_pkg::OP_WRITE
                                                  : i2cms_pkg::OP_READ,
                             8'($urandom), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) begin
                issue(i2cms_pkg::OP_RESTART, 8'($urandom), 1'b0);
                n = $urandom_range(1, 2);
                repeat (n) issue($urandom_range(0, 1) ? i2cms_pkg::OP_WRITE
                                                      : i2cms_pkg::OP_READ,
                                 8'($urandom), 1'($urandom_range(0, 1)));
            end
            issue(i2cms_pkg::OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) issue(3'($urandom_range(i2cms_pkg::OP_START, i2cms_pkg::OP_READ)),
                             8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        int phase_end;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // stop at the reset delays
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);
        settle();

        // zero delays, undefined codes, commands from any bus state
        set_delays(16'd0, 16'd0);
        send_req(OP_RSVD6, 8'hFF, 1'b1, 1'b1);
        send_req(OP_RSVD7, 8'h00, 1'b0, 1'b0);
        issue(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0);
        issue(i2cms_pkg::OP_READ, 8'h00, 1'b0);
        issue(i2cms_pkg::OP_READ, 8'hFF, 1'b1);
        issue(i2cms_pkg::OP_STOP, 8'hFF, 1'b1);
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);
        issue(i2cms_pkg::OP_START, 8'h00, 1'b0);
        issue(i2cms_pkg::OP_RESTART, 8'hFF, 1'b1);
        issue(i2cms_pkg::OP_WRITE, 8'h5A, 1'b0);
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);

        // random transactions over several delay settings, sharing the item budget
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            set_delays(pick_delay(), pick_delay());
            phase_end = sent_count + (ITEM_GOAL - sent_count) / (RAND_PHASES - p);
            while (sent_count < phase_end) begin
                run_transaction();
                if ($urandom_range(0, 9) == 0) drain();
            end
        end
        settle();

        end_of_test <= 1'b1;
        repeat (2) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/i2cms_pkg.sv
sv/i2c_master_byte_sequencer.sv
dv/i2c_master_byte_sequencer_chk.sv
dv/i2c_master_byte_sequencer_tb.sv
